// ===== rtl/core/fraction_reduce_gcd_top_assert.svh =====
// Assertion macros shared by the fraction reduction RTL.
// Needs no other file; include by bare name ahead of the module header.
`ifndef FRACTION_REDUCE_GCD_TOP_ASSERT_SVH
`define FRACTION_REDUCE_GCD_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FRG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define FRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/frg_pkg.sv =====
// Types and constants for the fraction reduction block.
// No dependencies; imported by every module of the block.
package frg_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DATA_W + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] num_in;
		logic signed [DATA_W-1:0] den_in;
	} frg_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] num_out;
		logic signed [DATA_W-1:0] den_out;
		logic                     invalid;
	} frg_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOD_WAIT,
		ST_QN_WAIT,
		ST_QD_WAIT
	} frg_state_t;

	typedef enum logic [1:0] {
		DIV_SEL_MOD,
		DIV_SEL_QN,
		DIV_SEL_QD
	} frg_div_sel_t;

	typedef struct packed {
		logic         load;
		logic         div_start;
		frg_div_sel_t div_sel;
		logic         gcd_step;
		logic         qn_take;
		logic         finish;
	} frg_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic b_zero;
		logic div_done;
	} frg_sts_t;

endpackage

// ===== rtl/core/fraction_reduce_gcd_top.sv =====
// From the accepting edge to the edge that takes the result: an invalid fraction (zero
// denominator) finishes straight from the check state. Otherwise each Euclid remainder step (up to
// ~46 steps) runs the bit-serial divider once, followed by the two quotient divisions and the
// result register.
// Throughput: one transaction at a time; busy is high from acceptance until the result
// is registered, and done is a one-cycle strobe the receiver cannot stall.
`include "fraction_reduce_gcd_top_assert.svh"

module fraction_reduce_gcd_top
	import frg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  frg_in_t  req,
	output logic     done,
	output frg_out_t res
);

	// Reset: arst_n asynchronously returns the controller to idle and clears the strobe.
	frg_cmd_t cmd;
	frg_sts_t sts;

	frg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	frg_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.res    (res)
	);

	`FRG_ASSERT_NOW(a_top_done_idle, clk, arst_n, done, !busy, "result strobed while still busy")
	`FRG_ASSERT_NOW(a_top_den_nonzero, clk, arst_n, done && !res.invalid, res.den_out != '0, "valid result with zero denominator")
	`FRG_ASSERT_NOW(a_top_invalid_den, clk, arst_n, done && res.invalid, res.den_out == '0, "invalid flag without zero denominator")

endmodule

// ===== rtl/core/frg_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on frg_pkg for the data width.
`include "fraction_reduce_gcd_top_assert.svh"

module frg_div
	import frg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quot,
	output logic [DATA_W-1:0] rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quot_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;
	logic                 qbit;
	logic [DATA_W-1:0]    next_rem;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial    = {rem_q, quot_q[DATA_W-1]};
		diff     = trial - {1'b0, dvs_q};
		qbit     = ~diff[DATA_W];
		next_rem = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
	end

	// Sequence the bit steps and pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= next_rem;
			quot_q <= {quot_q[DATA_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	`FRG_ASSERT_NOW(a_div_no_restart, clk, arst_n, start, !busy_q, "divider restarted while busy")
	`FRG_ASSERT_NEXT(a_div_done_after_busy, clk, arst_n, busy_q && cnt_q == DIV_CNT_W'(1) && !start, done_q, "divider missed its done pulse")
	`FRG_ASSERT_NOW(a_div_done_idle, clk, arst_n, done_q, !busy_q, "divider done while still busy")

endmodule

// ===== rtl/core/frg_dp.sv =====
// Datapath: operand magnitudes, Euclid registers, shared divider, result register.
// Depends on frg_pkg and frg_div.
module frg_dp
	import frg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  frg_in_t  req,
	input  frg_cmd_t cmd,
	output frg_sts_t sts,
	output logic     done,
	output frg_out_t res
);

	logic [DATA_W-1:0] num_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] an_q;
	logic [DATA_W-1:0] ad_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] qn_q;
	logic              neg_q;
	logic              valid_q;
	frg_out_t          res_q;

	logic [DATA_W-1:0] num_raw;
	logic [DATA_W-1:0] den_raw;
	logic [DATA_W-1:0] num_mag;
	logic [DATA_W-1:0] den_mag;
	logic [DATA_W-1:0] div_dividend;
	logic [DATA_W-1:0] div_divisor;
	logic              div_done;
	logic [DATA_W-1:0] div_quot;
	logic [DATA_W-1:0] div_rem;
	logic [DATA_W-1:0] num_red;

	// Take magnitudes of the incoming operands
	always_comb begin
		num_raw = DATA_W'(req.num_in);
		den_raw = DATA_W'(req.den_in);
		num_mag = num_raw[DATA_W-1] ? ('0 - num_raw) : num_raw;
		den_mag = den_raw[DATA_W-1] ? ('0 - den_raw) : den_raw;
	end

	// Select divider operands: remainder step, or a magnitude over the gcd
	always_comb begin
		unique case (cmd.div_sel)
			DIV_SEL_MOD: begin
				div_dividend = a_q;
				div_divisor  = b_q;
			end
			DIV_SEL_QN: begin
				div_dividend = an_q;
				div_divisor  = a_q;
			end
			DIV_SEL_QD: begin
				div_dividend = ad_q;
				div_divisor  = a_q;
			end
			default: begin
				div_dividend = a_q;
				div_divisor  = b_q;
			end
		endcase
	end

	frg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Capture operands, advance Euclid, hold the reduced numerator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= num_raw;
			den_q <= den_raw;
			an_q  <= num_mag;
			ad_q  <= den_mag;
			a_q   <= num_mag;
			b_q   <= den_mag;
			neg_q <= num_raw[DATA_W-1] ^ den_raw[DATA_W-1];
		end else if (cmd.gcd_step) begin
			a_q <= b_q;
			b_q <= div_rem;
		end
		if (cmd.qn_take) begin
			qn_q <= div_quot;
		end
	end

	// Apply the fraction's sign to the numerator, never to zero
	assign num_red = (neg_q && qn_q != '0) ? ('0 - qn_q) : qn_q;

	// Register the result for its one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (den_q == '0) begin
				res_q.num_out <= num_q;
				res_q.den_out <= den_q;
				res_q.invalid <= 1'b1;
			end else begin
				res_q.num_out <= num_red;
				res_q.den_out <= div_quot;
				res_q.invalid <= 1'b0;
			end
		end
	end

	assign sts.den_zero = (den_q == '0);
	assign sts.b_zero   = (b_q == '0);
	assign sts.div_done = div_done;
	assign done         = valid_q;
	assign res          = res_q;

endmodule

// ===== rtl/core/frg_ctrl.sv =====
// Controller state machine sequencing Euclid steps and the two final divisions.
// Depends on frg_pkg.
`include "fraction_reduce_gcd_top_assert.svh"

module frg_ctrl
	import frg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  frg_sts_t sts,
	output logic     busy,
	output frg_cmd_t cmd
);

	frg_state_t state_q;
	frg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (sts.den_zero) state_d = ST_IDLE;
				else if (sts.b_zero)       state_d = ST_QN_WAIT;
				else                       state_d = ST_MOD_WAIT;
			end
			ST_MOD_WAIT: begin
				if (sts.div_done) state_d = ST_CHECK;
			end
			ST_QN_WAIT: begin
				if (sts.div_done) state_d = ST_QD_WAIT;
			end
			ST_QD_WAIT: begin
				if (sts.div_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd         = '0;
		cmd.div_sel = DIV_SEL_MOD;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_CHECK: begin
				priority if (sts.den_zero) begin
					cmd.finish = 1'b1;
				end else if (sts.b_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_QN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_MOD;
				end
			end
			ST_MOD_WAIT: begin
				cmd.gcd_step = sts.div_done;
			end
			ST_QN_WAIT: begin
				cmd.qn_take   = sts.div_done;
				cmd.div_start = sts.div_done;
				cmd.div_sel   = DIV_SEL_QD;
			end
			ST_QD_WAIT: begin
				cmd.finish = sts.div_done;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`FRG_ASSERT_NEXT(a_ctrl_accept, clk, arst_n, start && state_q == ST_IDLE, state_q == ST_CHECK, "accepted transaction did not reach the check state")
	`FRG_ASSERT_NOW(a_ctrl_done_waiting, clk, arst_n, sts.div_done, state_q == ST_MOD_WAIT || state_q == ST_QN_WAIT || state_q == ST_QD_WAIT, "divider finished with no division pending")
	`FRG_ASSERT_NOW(a_ctrl_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.gcd_step, cmd.finish}), "conflicting datapath commands")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for fraction_reduce_gcd_top: signed fraction reduction by Euclid.
// Depends on frg_pkg and the RTL under rtl/core. It predicts each reduced fraction and
// checks every result strobe against the oldest outstanding transaction.
`timescale 1ns / 100ps

module tb;
	import frg_pkg::*;

	localparam int unsigned RAND_ITEMS    = 450;
	localparam int unsigned STALL_LIMIT   = 20000;
	localparam int unsigned DRAIN_CYCLES  = 40;
	localparam int unsigned REPORT_MAX    = 10;
	localparam logic [31:0] POS_MAX       = 32'h7FFF_FFFF;

	// Expected reduced fractions, oldest first
	class frac_scoreboard;
		frg_out_t    reduced_q[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Reduce one fraction to lowest terms, sign on the numerator
		function frg_out_t reduce_fraction(frg_in_t f);
			frg_out_t    r;
			logic [31:0] n, d, mag_n, mag_d, a, b, t, qn, qd;
			logic        neg;
			n = f.num_in;
			d = f.den_in;
			r.invalid = 1'b0;
			if (d == 32'd0) begin
				r.num_out = n;
				r.den_out = d;
				r.invalid = 1'b1;
				return r;
			end
			mag_n = n[31] ? (32'd0 - n) : n;
			mag_d = d[31] ? (32'd0 - d) : d;
			a = mag_n;
			b = mag_d;
			while (b != 32'd0) begin
				t = b;
				b = a % b;
				a = t;
			end
			qn = mag_n / a;
			qd = mag_d / a;
			neg = (n[31] ^ d[31]) && (qn != 32'd0);
			r.num_out = neg ? (32'd0 - qn) : qn;
			r.den_out = qd;
			return r;
		endfunction

		function void note_fraction(frg_in_t f);
			reduced_q.push_back(reduce_fraction(f));
		endfunction

		function void check_result(frg_out_t got);
			frg_out_t want;
			if (reduced_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: num=%0d den=%0d invalid=%0b",
						got.num_out, got.den_out, got.invalid);
				return;
			end
			want = reduced_q.pop_front();
			if (got.num_out !== want.num_out || got.den_out !== want.den_out ||
					got.invalid !== want.invalid) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch: expected %0d/%0d inv=%0b, got %0d/%0d inv=%0b",
						want.num_out, want.den_out, want.invalid,
						got.num_out, got.den_out, got.invalid);
			end
		endfunction

		function int unsigned pending();
			return reduced_q.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	frg_in_t  req;
	logic     done;
	frg_out_t res;

	frac_scoreboard sb;
	int unsigned    stall_cnt;

	fraction_reduce_gcd_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Score results first, then note the transaction accepted at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(res);
			if (start && !busy)
				sb.note_fraction(req);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// Present one fraction and hold it until the block takes it
	task automatic send_fraction(input logic [31:0] n, input logic [31:0] d);
		frg_in_t f;
		f.num_in = n;
		f.den_in = d;
		req   <= f;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a random gap; mostly short, now and then long
	task automatic idle_sender(input bit no_gap);
		int unsigned r, gap;
		r = $urandom_range(0, 99);
		if (no_gap || r < 40)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 4);
		else if (r < 97)
			gap = $urandom_range(5, 20);
		else
			gap = $urandom_range(30, 80);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] apply_sign(input logic [31:0] m);
		return $urandom_range(0, 1) ? (32'd0 - m) : m;
	endfunction

	// Operand across the legal range, biased towards small magnitudes now and then
	function automatic logic [31:0] pick_operand();
		int unsigned sel;
		logic [31:0] m;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			m = $urandom & POS_MAX;
		else if (sel < 8)
			m = $urandom_range(1, 1000);
		else
			m = $urandom_range(0, 15);
		return apply_sign(m);
	endfunction

	task automatic send_random_fraction(input bit no_gap);
		int unsigned kind, g, a, b;
		logic [31:0] n, d;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			n = 32'd0;
			d = pick_operand();
		end else if (kind == 1) begin
			n = pick_operand();
			d = 32'd0;
		end else if (kind < 9) begin
			// Shared factor so that the reduction actually divides something out
			g = $urandom_range(2, 65535);
			a = $urandom_range(0, 32767);
			b = $urandom_range(1, 32767);
			n = apply_sign(a * g);
			d = apply_sign(b * g);
		end else begin
			n = pick_operand();
			d = pick_operand();
		end
		send_fraction(n, d);
		idle_sender(no_gap);
	endtask

	initial begin
		logic [31:0] dir_num[$];
		logic [31:0] dir_den[$];
		sb        = new();
		stall_cnt = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed fractions: zeros, extremes, signs, worst-case Euclid chain
		dir_num = '{32'd0, 32'd0, 32'd7, -32'sd7, 32'd0, POS_MAX, POS_MAX,
			-POS_MAX, -POS_MAX, 32'd1, -32'sd1, 32'd6, 32'd12,
			32'd1836311903, -32'sd1134903170, POS_MAX, 32'd1, 32'd1,
			32'h4000_0000, -32'sh4000_0000, 32'd2147483629, 32'hAAAA_AAAA & POS_MAX,
			32'd5};
		dir_den = '{32'd5, -32'sd5, 32'd0, 32'd0, 32'd0, POS_MAX, -POS_MAX,
			POS_MAX, -POS_MAX, 32'd1, 32'd1, -32'sd4, 32'd18,
			32'd1134903170, 32'd1836311903, 32'd1, POS_MAX, -POS_MAX,
			32'h2000_0000, -32'sh0000_0006, 32'd2147483587, 32'h5555_5555,
			-32'sd10};
		foreach (dir_num[i]) begin
			send_fraction(dir_num[i], dir_den[i]);
			idle_sender(1'b0);
		end

		// Random fractions, with a back-to-back stretch and one full drain
		for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 2) begin
				start <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			send_random_fraction(i >= 100 && i < 140);
		end
		start <= 1'b0;

		// Drain outstanding results, then watch for stray strobes
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/frg_pkg.sv
rtl/core/frg_div.sv
rtl/core/frg_dp.sv
rtl/core/frg_ctrl.sv
rtl/core/fraction_reduce_gcd_top.sv
dv/tb.sv
